/* src/ngrfd_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ngrfd_pkg
// Shared types, character codes and field tables of the GGA / RMC decoder.
// ----------------------------------------------------------------------------
package ngrfd_pkg;

	// kind of sentence found in the identifier
	typedef enum logic [1:0] {
		KIND_NONE = 2'd0,
		KIND_GGA  = 2'd1,
		KIND_RMC  = 2'd2
	} kind_t;

	// result status codes
	localparam logic [1:0] STATUS_GGA    = 2'd0;
	localparam logic [1:0] STATUS_RMC    = 2'd1;
	localparam logic [1:0] STATUS_REJECT = 2'd2;

	// characters of interest
	localparam logic [7:0] CHAR_COMMA = 8'h2C;
	localparam logic [7:0] CHAR_SOUTH = 8'h53;
	localparam logic [7:0] CHAR_EAST  = 8'h45;
	localparam logic [7:0] CHAR_VALID = 8'h41;

	// identifier length and counter limits
	localparam logic [3:0] ID_LEN      = 4'd6;
	localparam logic [3:0] ID_LAST_POS = 4'd5;
	localparam logic [3:0] CNT_MAX     = 4'd15;
	localparam logic [4:0] FIELD_MAX   = 5'd31;

	// field positions that carry decoded values
	localparam logic [4:0] GGA_F_TIME  = 5'd1;
	localparam logic [4:0] GGA_F_LAT   = 5'd2;
	localparam logic [4:0] GGA_F_NS    = 5'd3;
	localparam logic [4:0] GGA_F_LON   = 5'd4;
	localparam logic [4:0] GGA_F_EW    = 5'd5;
	localparam logic [4:0] GGA_F_FIX   = 5'd6;
	localparam logic [4:0] RMC_F_TIME  = 5'd1;
	localparam logic [4:0] RMC_F_STAT  = 5'd2;
	localparam logic [4:0] RMC_F_LAT   = 5'd3;
	localparam logic [4:0] RMC_F_NS    = 5'd4;
	localparam logic [4:0] RMC_F_LON   = 5'd5;
	localparam logic [4:0] RMC_F_EW    = 5'd6;

	// update controls produced when a field closes
	typedef struct packed {
		logic fail;
		logic time_we;
		logic lat_we;
		logic lon_we;
		logic south_we;
		logic east_we;
		logic fix_we;
	} close_ctl_t;

	// identifier characters, "$GPGGA" or "$GPRMC"
	function automatic logic [7:0] id_char(input logic rmc, input logic [2:0] pos);
		logic [7:0] c;
		unique case (pos)
			3'd0:    c = 8'h24;
			3'd1:    c = 8'h47;
			3'd2:    c = 8'h50;
			3'd3:    c = rmc ? 8'h52 : 8'h47;
			3'd4:    c = rmc ? 8'h4D : 8'h47;
			3'd5:    c = rmc ? 8'h43 : 8'h41;
			default: c = 8'h00;
		endcase
		return c;
	endfunction

	// allowed field length including the comma, zero past the table
	function automatic logic [3:0] field_limit(input kind_t kind, input logic [4:0] n);
		logic [3:0] lim;
		lim = 4'd0;
		unique case (kind)
			KIND_GGA: begin
				unique case (n)
					5'd0:    lim = 4'd6;
					5'd1:    lim = 4'd11;
					5'd2:    lim = 4'd10;
					5'd3:    lim = 4'd2;
					5'd4:    lim = 4'd11;
					5'd5:    lim = 4'd2;
					5'd6:    lim = 4'd2;
					5'd7:    lim = 4'd3;
					5'd8:    lim = 4'd6;
					5'd9:    lim = 4'd8;
					5'd10:   lim = 4'd2;
					5'd11:   lim = 4'd8;
					5'd12:   lim = 4'd2;
					5'd13:   lim = 4'd4;
					5'd14:   lim = 4'd4;
					5'd15:   lim = 4'd3;
					default: lim = 4'd0;
				endcase
			end
			KIND_RMC: begin
				unique case (n)
					5'd0:    lim = 4'd6;
					5'd1:    lim = 4'd11;
					5'd2:    lim = 4'd2;
					5'd3:    lim = 4'd10;
					5'd4:    lim = 4'd2;
					5'd5:    lim = 4'd11;
					5'd6:    lim = 4'd2;
					5'd7:    lim = 4'd8;
					5'd8:    lim = 4'd8;
					5'd9:    lim = 4'd8;
					5'd10:   lim = 4'd6;
					5'd11:   lim = 4'd2;
					5'd12:   lim = 4'd2;
					5'd13:   lim = 4'd3;
					default: lim = 4'd0;
				endcase
			end
			default: lim = 4'd0;
		endcase
		return lim;
	endfunction

endpackage

/* src/nmea_gga_rmc_field_decoder_core.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nmea_gga_rmc_field_decoder_core
// Byte-wide GGA / RMC sentence parser with registered decoded results.
// ----------------------------------------------------------------------------
// One sentence byte is taken per clock. A byte is held in the input
// register, where the field state, the length check and the decode are
// updated in a single pass; the byte flagged last produces one result
// transaction, captured in the result register as the byte leaves the
// input register. Throughput is one byte per cycle, and input ready only
// drops when the last byte of a sentence finds the result register still
// occupied. FIELD_CHARS (11 to 16) sets how many field characters are kept.
module nmea_gga_rmc_field_decoder_core #(
	parameter int FIELD_CHARS = 12
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  sentence_byte,
	input  logic        last_byte,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [1:0]  status,
	output logic [7:0]  utc_hours,
	output logic [7:0]  utc_minutes,
	output logic [7:0]  utc_seconds,
	output logic [7:0]  lat_degrees,
	output logic [7:0]  lat_minutes,
	output logic [14:0] lat_fraction,
	output logic [10:0] lon_degrees,
	output logic [7:0]  lon_minutes,
	output logic [14:0] lon_fraction,
	output logic [1:0]  hemisphere_bits,
	output logic [3:0]  fix_quality
);
	import ngrfd_pkg::*;

	localparam int IDX_W = $clog2(FIELD_CHARS);

	// input register
	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       last_s1;
	logic       adv;

	// sentence state
	logic [4:0] field_q, field_d;
	logic [3:0] cnt_q, cnt_d, cnt_w;
	logic [7:0] first_q, first_d, first_w;
	logic [1:0] idm_q, idm_d, idm_t;
	kind_t      kind_q, kind_d;
	logic       err_q, err_d;
	logic [3:0] digit_q [FIELD_CHARS];
	logic [3:0] digit_d [FIELD_CHARS];
	logic [3:0] digit_w [FIELD_CHARS];

	// decoded stores
	logic [7:0]  hrs_q, hrs_d, min_q, min_d, sec_q, sec_d;
	logic [7:0]  latd_q, latd_d, latm_q, latm_d;
	logic [14:0] latf_q, latf_d, lonf_q, lonf_d;
	logic [10:0] lond_q, lond_d;
	logic [7:0]  lonm_q, lonm_d;
	logic        south_q, south_d, east_q, east_d;
	logic [3:0]  fix_q, fix_d;
	logic [1:0]  status_n;

	// close decode outputs
	close_ctl_t  ctl;
	logic [7:0]  c_hrs, c_min, c_sec, c_latd, c_latm, c_lonm;
	logic [14:0] c_latf, c_lonf;
	logic [10:0] c_lond;
	logic        c_south, c_east;
	logic [3:0]  c_fix;

	// handshake: the last byte needs a free result slot
	assign adv      = valid_s1 && (!last_s1 || !out_valid || out_ready);
	assign in_ready = !valid_s1 || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_valid && in_ready) begin
			valid_s1 <= 1'b1;
		end else if (adv) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			byte_s1 <= sentence_byte;
			last_s1 <= last_byte;
		end
	end

	// field data with the current byte written in
	always_comb begin
		digit_w = digit_q;
		if ({1'b0, cnt_q} < 5'(FIELD_CHARS)) begin
			digit_w[cnt_q[IDX_W-1:0]] = byte_s1[3:0];
		end
		first_w = (cnt_q == 4'd0) ? byte_s1 : first_q;
		cnt_w   = (cnt_q == CNT_MAX) ? cnt_q : cnt_q + 4'd1;
	end

	ngrfd_field_close #(
		.FIELD_CHARS(FIELD_CHARS)
	) u_close (
		.kind      (kind_q),
		.field_num (field_q),
		.char_cnt  (cnt_w),
		.first_ch  (first_w),
		.digits    (digit_w),
		.ctl       (ctl),
		.hours     (c_hrs),
		.minutes   (c_min),
		.seconds   (c_sec),
		.lat_deg   (c_latd),
		.lat_min   (c_latm),
		.lat_frac  (c_latf),
		.lon_deg   (c_lond),
		.lon_min   (c_lonm),
		.lon_frac  (c_lonf),
		.south     (c_south),
		.east      (c_east),
		.fix       (c_fix)
	);

	// next sentence state and stores
	always_comb begin
		field_d = field_q;
		cnt_d   = cnt_q;
		first_d = first_q;
		idm_d   = idm_q;
		idm_t   = idm_q;
		kind_d  = kind_q;
		err_d   = err_q;
		digit_d = digit_q;
		hrs_d   = hrs_q;
		min_d   = min_q;
		sec_d   = sec_q;
		latd_d  = latd_q;
		latm_d  = latm_q;
		latf_d  = latf_q;
		lond_d  = lond_q;
		lonm_d  = lonm_q;
		lonf_d  = lonf_q;
		south_d = south_q;
		east_d  = east_q;
		fix_d   = fix_q;
		if (adv && !err_q) begin
			if (field_q == 5'd0) begin
				// identifier and the rest of field 0
				if (cnt_q < ID_LEN) begin
					if (byte_s1 != id_char(1'b0, cnt_q[2:0])) idm_t[0] = 1'b0;
					if (byte_s1 != id_char(1'b1, cnt_q[2:0])) idm_t[1] = 1'b0;
					idm_d = idm_t;
					if (cnt_q == ID_LAST_POS) begin
						priority if (idm_t[0]) begin
							kind_d = KIND_GGA;
						end else if (idm_t[1]) begin
							kind_d = KIND_RMC;
						end else begin
							err_d = 1'b1;
						end
					end
					cnt_d = cnt_q + 4'd1;
				end else if (byte_s1 == CHAR_COMMA) begin
					field_d = 5'd1;
					cnt_d   = 4'd0;
					first_d = 8'd0;
					for (int i = 0; i < FIELD_CHARS; i++) digit_d[i] = 4'd0;
				end else if (cnt_q != CNT_MAX) begin
					cnt_d = cnt_q + 4'd1;
				end
			end else begin
				first_d = first_w;
				digit_d = digit_w;
				cnt_d   = cnt_w;
				// field closes at a comma or the last byte
				if (byte_s1 == CHAR_COMMA || last_s1) begin
					if (ctl.fail) err_d = 1'b1;
					if (ctl.time_we) begin
						hrs_d = c_hrs;
						min_d = c_min;
						sec_d = c_sec;
					end
					if (ctl.lat_we) begin
						latd_d = c_latd;
						latm_d = c_latm;
						latf_d = c_latf;
					end
					if (ctl.lon_we) begin
						lond_d = c_lond;
						lonm_d = c_lonm;
						lonf_d = c_lonf;
					end
					if (ctl.south_we) south_d = c_south;
					if (ctl.east_we) east_d = c_east;
					if (ctl.fix_we) fix_d = c_fix;
				end
				// open the next field
				if (byte_s1 == CHAR_COMMA && !last_s1) begin
					if (field_q != FIELD_MAX) field_d = field_q + 5'd1;
					cnt_d   = 4'd0;
					first_d = 8'd0;
					for (int i = 0; i < FIELD_CHARS; i++) digit_d[i] = 4'd0;
				end
			end
		end
		// sentence status before the per-sentence state is cleared
		if (err_d || kind_d == KIND_NONE) begin
			status_n = STATUS_REJECT;
		end else if (kind_d == KIND_GGA) begin
			status_n = STATUS_GGA;
		end else begin
			status_n = STATUS_RMC;
		end
		if (adv && last_s1) begin
			field_d = 5'd0;
			cnt_d   = 4'd0;
			first_d = 8'd0;
			idm_d   = 2'b11;
			kind_d  = KIND_NONE;
			err_d   = 1'b0;
			for (int i = 0; i < FIELD_CHARS; i++) digit_d[i] = 4'd0;
		end
	end

	// state and store registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			field_q <= 5'd0;
			cnt_q   <= 4'd0;
			first_q <= 8'd0;
			idm_q   <= 2'b11;
			kind_q  <= KIND_NONE;
			err_q   <= 1'b0;
			for (int i = 0; i < FIELD_CHARS; i++) digit_q[i] <= 4'd0;
			hrs_q   <= 8'd0;
			min_q   <= 8'd0;
			sec_q   <= 8'd0;
			latd_q  <= 8'd0;
			latm_q  <= 8'd0;
			latf_q  <= 15'd0;
			lond_q  <= 11'd0;
			lonm_q  <= 8'd0;
			lonf_q  <= 15'd0;
			south_q <= 1'b0;
			east_q  <= 1'b0;
			fix_q   <= 4'd0;
		end else begin
			field_q <= field_d;
			cnt_q   <= cnt_d;
			first_q <= first_d;
			idm_q   <= idm_d;
			kind_q  <= kind_d;
			err_q   <= err_d;
			digit_q <= digit_d;
			hrs_q   <= hrs_d;
			min_q   <= min_d;
			sec_q   <= sec_d;
			latd_q  <= latd_d;
			latm_q  <= latm_d;
			latf_q  <= latf_d;
			lond_q  <= lond_d;
			lonm_q  <= lonm_d;
			lonf_q  <= lonf_d;
			south_q <= south_d;
			east_q  <= east_d;
			fix_q   <= fix_d;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (adv && last_s1) begin
			out_valid <= 1'b1;
		end else if (out_ready) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && last_s1) begin
			status          <= status_n;
			utc_hours       <= hrs_d;
			utc_minutes     <= min_d;
			utc_seconds     <= sec_d;
			lat_degrees     <= latd_d;
			lat_minutes     <= latm_d;
			lat_fraction    <= latf_d;
			lon_degrees     <= lond_d;
			lon_minutes     <= lonm_d;
			lon_fraction    <= lonf_d;
			hemisphere_bits <= {east_d, south_d};
			fix_quality     <= fix_d;
		end
	end

endmodule

/* src/ngrfd_field_close.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ngrfd_field_close
// Length check and value decode of a field at its closing character.
// ----------------------------------------------------------------------------
module ngrfd_field_close #(
	parameter int FIELD_CHARS = 12
) (
	input  ngrfd_pkg::kind_t      kind,
	input  logic [4:0]            field_num,
	input  logic [3:0]            char_cnt,
	input  logic [7:0]            first_ch,
	input  logic [3:0]            digits [FIELD_CHARS],
	output ngrfd_pkg::close_ctl_t ctl,
	output logic [7:0]            hours,
	output logic [7:0]            minutes,
	output logic [7:0]            seconds,
	output logic [7:0]            lat_deg,
	output logic [7:0]            lat_min,
	output logic [14:0]           lat_frac,
	output logic [10:0]           lon_deg,
	output logic [7:0]            lon_min,
	output logic [14:0]           lon_frac,
	output logic                  south,
	output logic                  east,
	output logic [3:0]            fix
);
	import ngrfd_pkg::*;

	logic len_bad;

	// two-, three- and four-digit decimal values from the stored nibbles
	assign hours    = {4'd0, digits[0]} * 8'd10 + {4'd0, digits[1]};
	assign minutes  = {4'd0, digits[2]} * 8'd10 + {4'd0, digits[3]};
	assign seconds  = {4'd0, digits[4]} * 8'd10 + {4'd0, digits[5]};
	assign lat_deg  = {4'd0, digits[0]} * 8'd10 + {4'd0, digits[1]};
	assign lat_min  = {4'd0, digits[2]} * 8'd10 + {4'd0, digits[3]};
	// fifth character is the dot
	assign lat_frac = {11'd0, digits[5]} * 15'd1000 + {11'd0, digits[6]} * 15'd100
	                + {11'd0, digits[7]} * 15'd10 + {11'd0, digits[8]};
	assign lon_deg  = {7'd0, digits[0]} * 11'd100 + {7'd0, digits[1]} * 11'd10
	                + {7'd0, digits[2]};
	assign lon_min  = {4'd0, digits[3]} * 8'd10 + {4'd0, digits[4]};
	// sixth character is the dot
	assign lon_frac = {11'd0, digits[6]} * 15'd1000 + {11'd0, digits[7]} * 15'd100
	                + {11'd0, digits[8]} * 15'd10 + {11'd0, digits[9]};
	assign south    = (first_ch == CHAR_SOUTH);
	assign east     = (first_ch == CHAR_EAST);
	assign fix      = digits[0];

	assign len_bad = (char_cnt > field_limit(kind, field_num));

	// per-type field actions
	always_comb begin
		ctl = '0;
		if (len_bad) begin
			ctl.fail = 1'b1;
		end else if (kind == KIND_GGA) begin
			ctl.time_we  = (field_num == GGA_F_TIME);
			ctl.lat_we   = (field_num == GGA_F_LAT);
			ctl.south_we = (field_num == GGA_F_NS);
			ctl.lon_we   = (field_num == GGA_F_LON);
			ctl.east_we  = (field_num == GGA_F_EW);
			ctl.fix_we   = (field_num == GGA_F_FIX);
			// no fix means the position is unusable
			ctl.fail     = (field_num == GGA_F_FIX) && (digits[0] == 4'd0);
		end else begin
			ctl.time_we  = (field_num == RMC_F_TIME);
			ctl.lat_we   = (field_num == RMC_F_LAT);
			ctl.south_we = (field_num == RMC_F_NS);
			ctl.lon_we   = (field_num == RMC_F_LON);
			ctl.east_we  = (field_num == RMC_F_EW);
			ctl.fail     = (field_num == RMC_F_STAT) && (first_ch != CHAR_VALID);
		end
	end

endmodule
